/* sv/mfr_pkg.sv */
// Shared constants, types and codes of the frame receiver.
package mfr_pkg;

   localparam int BUFFER_DEPTH = 64;
   localparam int BUF_AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int CNT_W = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CNT_W-1:0] BUFFER_DEPTH_C = CNT_W'(BUFFER_DEPTH);

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic ST_PAYLOAD = 1'b0;
   localparam logic ST_TIMEOUT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_PAYLOAD = 2'd1;

   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
   localparam logic [6:0] MAX_PAYLOAD_RESET = 7'd64;

   localparam logic [7:0] HDR_DOLLAR = 8'h24;
   localparam logic [7:0] HDR_EM = 8'h4D;
   localparam logic [7:0] HDR_LESS = 8'h3C;

   typedef struct packed {
      logic hdr_store;
      logic hdr_clear;
      logic frame_clear;
      logic take_size;
      logic take_id;
      logic take_data;
      logic tick;
      logic emit_start;
      logic emit_read;
      logic emit_next;
      logic show_frame;
      logic show_timeout;
   } mfr_cmd_type;

   typedef struct packed {
      logic hdr_busy;
      logic hdr_full;
      logic hdr_ok;
      logic size_zero;
      logic data_done;
      logic csum_ok;
      logic eff_zero;
      logic tick_timeout;
      logic emit_last;
   } mfr_status_type;

endpackage

/* sv/msp_frame_receiver.sv */
// Top level of the serial command frame receiver.
//
// The req_ channel carries one word per received byte (req_opcode = 0) or per
// time tick (req_opcode = 1). Bytes and ticks are taken while the block hunts
// for or collects a frame; the frame is checked against its XOR checksum.
// A good frame yields max_payload words on the rsp_ channel (clipped to the
// buffer depth), stored bytes first and then zero fill, rsp_last on the final
// one. Each of these words is first read from the payload store read port and
// then presented, so the first word follows the checksum byte through the read
// state and then the show state. A timeout gives one word with rsp_status
// set, valid in the cycle after the tick that caused it.
// While result words are pending, req_ready is low; a stalled receiver holds
// rsp_valid and the word until rsp_ready, and input waits meanwhile.
// Registers are written through csr_ at any idle moment, one per cycle.
// Synchronous reset restores the register defaults and returns the block to
// header hunting at once; the payload store is not cleared.
module msp_frame_receiver
   import mfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_opcode,
   input  logic [7:0]            req_rx_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_status,
   output logic [7:0]            rsp_message_id,
   output logic [7:0]            rsp_payload_size,
   output logic [5:0]            rsp_byte_index,
   output logic [7:0]            rsp_data_byte,
   output logic                  rsp_last,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   mfr_cmd_type    cmd;
   mfr_status_type sts;

   mfr_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .rsp_ready  (rsp_ready),
      .sts        (sts),
      .cmd        (cmd),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid)
   );

   mfr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .rx_byte          (req_rx_byte),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .sts              (sts),
      .rsp_status       (rsp_status),
      .rsp_message_id   (rsp_message_id),
      .rsp_payload_size (rsp_payload_size),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_last         (rsp_last)
   );

endmodule

/* sv/mfr_datapath.sv */
// Datapath of the frame receiver: header, checksum, tick timer, payload store and result fields.
module mfr_datapath
   import mfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  mfr_cmd_type           cmd,
   input  logic [7:0]            rx_byte,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output mfr_status_type        sts,
   output logic                  rsp_status,
   output logic [7:0]            rsp_message_id,
   output logic [7:0]            rsp_payload_size,
   output logic [5:0]            rsp_byte_index,
   output logic [7:0]            rsp_data_byte,
   output logic                  rsp_last
);

   logic [15:0]      timeout_ff, timeout_in;
   logic [6:0]       max_ff, max_in;
   logic [1:0]       hdr_cnt_ff, hdr_cnt_in;
   logic [7:0]       hdr0_ff, hdr0_in;
   logic [7:0]       hdr1_ff, hdr1_in;
   logic [7:0]       frame_size_ff, frame_size_in;
   logic [7:0]       frame_id_ff, frame_id_in;
   logic [CNT_W-1:0] pay_cnt_ff, pay_cnt_in;
   logic [7:0]       xor_ff, xor_in;
   logic [15:0]      elapsed_ff, elapsed_in;
   logic [CNT_W-1:0] emit_idx_ff, emit_idx_in;
   logic [7:0]       rd_data_ff;

   logic [7:0]       store_mem [BUFFER_DEPTH];

   logic [CNT_W-1:0] eff_max;
   logic [15:0]      elapsed_next;
   logic             store_en;
   logic [CNT_W:0]   pay_cnt_inc;
   logic [CNT_W:0]   emit_idx_inc;

   // The effective maximum is the configured one clipped to the buffer.
   always_comb begin
      if (CNT_W'(max_ff) > BUFFER_DEPTH_C) begin
         eff_max = BUFFER_DEPTH_C;
      end else begin
         eff_max = CNT_W'(max_ff);
      end
   end

   assign elapsed_next = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;
   assign store_en     = (pay_cnt_ff < eff_max) && (pay_cnt_ff < BUFFER_DEPTH_C);
   assign pay_cnt_inc  = {1'b0, pay_cnt_ff} + {{CNT_W{1'b0}}, 1'b1};
   assign emit_idx_inc = {1'b0, emit_idx_ff} + {{CNT_W{1'b0}}, 1'b1};

   assign sts.hdr_busy     = (hdr_cnt_ff != 2'd0);
   assign sts.hdr_full     = (hdr_cnt_ff == 2'd2);
   assign sts.hdr_ok       = (hdr0_ff == HDR_DOLLAR) && (hdr1_ff == HDR_EM) &&
                             (rx_byte == HDR_LESS);
   assign sts.size_zero    = (frame_size_ff == 8'd0);
   assign sts.data_done    = (pay_cnt_inc >= {1'b0, frame_size_ff});
   assign sts.csum_ok      = (rx_byte == xor_ff);
   assign sts.eff_zero     = (eff_max == {CNT_W{1'b0}});
   assign sts.tick_timeout = (elapsed_next >= timeout_ff);
   assign sts.emit_last    = (emit_idx_inc == {1'b0, eff_max});

   always_comb begin
      timeout_in    = timeout_ff;
      max_in        = max_ff;
      hdr_cnt_in    = hdr_cnt_ff;
      hdr0_in       = hdr0_ff;
      hdr1_in       = hdr1_ff;
      frame_size_in = frame_size_ff;
      frame_id_in   = frame_id_ff;
      pay_cnt_in    = pay_cnt_ff;
      xor_in        = xor_ff;
      elapsed_in    = elapsed_ff;
      emit_idx_in   = emit_idx_ff;

      if (csr_write_enable) begin
         if (csr_index == REG_TIMEOUT_TICKS) begin
            timeout_in = csr_write_data[15:0];
         end else if (csr_index == REG_MAX_PAYLOAD) begin
            max_in = csr_write_data[6:0];
         end
      end

      if (cmd.frame_clear) begin
         hdr_cnt_in    = 2'd0;
         hdr0_in       = 8'd0;
         hdr1_in       = 8'd0;
         frame_size_in = 8'd0;
         frame_id_in   = 8'd0;
         pay_cnt_in    = {CNT_W{1'b0}};
         xor_in        = 8'd0;
         elapsed_in    = 16'd0;
      end else begin
         if (cmd.hdr_store) begin
            // The third header byte is never held: it is checked as it arrives.
            if (hdr_cnt_ff == 2'd0) begin
               hdr0_in    = rx_byte;
               elapsed_in = 16'd0;
            end else begin
               hdr1_in = rx_byte;
            end
            hdr_cnt_in = hdr_cnt_ff + 2'd1;
         end
         if (cmd.hdr_clear) begin
            hdr_cnt_in = 2'd0;
            hdr0_in    = 8'd0;
            hdr1_in    = 8'd0;
         end
         if (cmd.take_size) begin
            frame_size_in = rx_byte;
            xor_in        = rx_byte;
         end
         if (cmd.take_id) begin
            frame_id_in = rx_byte;
            xor_in      = xor_ff ^ rx_byte;
            pay_cnt_in  = {CNT_W{1'b0}};
         end
         if (cmd.take_data) begin
            xor_in     = xor_ff ^ rx_byte;
            pay_cnt_in = pay_cnt_inc[CNT_W-1:0];
         end
         if (cmd.tick) begin
            elapsed_in = elapsed_next;
         end
      end

      if (cmd.emit_start) begin
         emit_idx_in = {CNT_W{1'b0}};
      end else if (cmd.emit_next) begin
         emit_idx_in = emit_idx_inc[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff    <= TIMEOUT_RESET;
         max_ff        <= MAX_PAYLOAD_RESET;
         hdr_cnt_ff    <= 2'd0;
         hdr0_ff       <= 8'd0;
         hdr1_ff       <= 8'd0;
         frame_size_ff <= 8'd0;
         frame_id_ff   <= 8'd0;
         pay_cnt_ff    <= {CNT_W{1'b0}};
         xor_ff        <= 8'd0;
         elapsed_ff    <= 16'd0;
         emit_idx_ff   <= {CNT_W{1'b0}};
      end else begin
         timeout_ff    <= timeout_in;
         max_ff        <= max_in;
         hdr_cnt_ff    <= hdr_cnt_in;
         hdr0_ff       <= hdr0_in;
         hdr1_ff       <= hdr1_in;
         frame_size_ff <= frame_size_in;
         frame_id_ff   <= frame_id_in;
         pay_cnt_ff    <= pay_cnt_in;
         xor_ff        <= xor_in;
         elapsed_ff    <= elapsed_in;
         emit_idx_ff   <= emit_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take_data && store_en) begin
         store_mem[pay_cnt_ff[BUF_AW-1:0]] <= rx_byte;
      end
      if (cmd.emit_read) begin
         rd_data_ff <= store_mem[emit_idx_ff[BUF_AW-1:0]];
      end
   end

   always_comb begin
      rsp_status       = ST_PAYLOAD;
      rsp_message_id   = 8'd0;
      rsp_payload_size = 8'd0;
      rsp_byte_index   = 6'd0;
      rsp_data_byte    = 8'd0;
      rsp_last         = 1'b0;
      if (cmd.show_timeout) begin
         rsp_status = ST_TIMEOUT;
         rsp_last   = 1'b1;
      end else if (cmd.show_frame) begin
         rsp_message_id   = frame_id_ff;
         rsp_payload_size = frame_size_ff;
         rsp_byte_index   = emit_idx_ff[5:0];
         // Positions past the received size are zero filled.
         rsp_data_byte    = (emit_idx_ff < frame_size_ff) ? rd_data_ff : 8'd0;
         rsp_last         = sts.emit_last;
      end
   end

endmodule

/* sv/mfr_controller.sv */
// Controller of the frame receiver: frame phase and result sequencing.
module mfr_controller
   import mfr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_opcode,
   input  logic           rsp_ready,
   input  mfr_status_type sts,
   output mfr_cmd_type    cmd,
   output logic           req_ready,
   output logic           rsp_valid
);

   localparam logic [2:0] S_HUNT      = 3'd0;
   localparam logic [2:0] S_SIZE      = 3'd1;
   localparam logic [2:0] S_ID        = 3'd2;
   localparam logic [2:0] S_DATA      = 3'd3;
   localparam logic [2:0] S_CSUM      = 3'd4;
   localparam logic [2:0] S_EMIT_RD   = 3'd5;
   localparam logic [2:0] S_EMIT_SHOW = 3'd6;
   localparam logic [2:0] S_TO_SHOW   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       take;
   logic       busy;

   assign req_ready = (state_ff == S_HUNT) || (state_ff == S_SIZE) || (state_ff == S_ID) ||
                      (state_ff == S_DATA) || (state_ff == S_CSUM);
   assign rsp_valid = (state_ff == S_EMIT_SHOW) || (state_ff == S_TO_SHOW);
   assign take      = req_valid && req_ready;
   assign busy      = (state_ff != S_HUNT) || sts.hdr_busy;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;

      if (take && (req_opcode == OP_TICK)) begin
         // A tick only counts while a frame is in progress.
         if (busy) begin
            cmd.tick = 1'b1;
            if (sts.tick_timeout) begin
               cmd.frame_clear = 1'b1;
               state_in        = S_TO_SHOW;
            end
         end
      end else if (take) begin
         unique case (state_ff)
            S_HUNT: begin
               if (sts.hdr_full) begin
                  if (sts.hdr_ok) begin
                     cmd.hdr_clear = 1'b1;
                     state_in      = S_SIZE;
                  end else begin
                     cmd.frame_clear = 1'b1;
                  end
               end else begin
                  cmd.hdr_store = 1'b1;
               end
            end
            S_SIZE: begin
               cmd.take_size = 1'b1;
               state_in      = S_ID;
            end
            S_ID: begin
               cmd.take_id = 1'b1;
               state_in    = sts.size_zero ? S_CSUM : S_DATA;
            end
            S_DATA: begin
               cmd.take_data = 1'b1;
               if (sts.data_done) begin
                  state_in = S_CSUM;
               end
            end
            S_CSUM: begin
               // Frame fields are kept until the last result word has gone.
               if (sts.csum_ok && !sts.eff_zero) begin
                  cmd.emit_start = 1'b1;
                  state_in       = S_EMIT_RD;
               end else begin
                  cmd.frame_clear = 1'b1;
                  state_in        = S_HUNT;
               end
            end
            default: begin
               state_in = state_ff;
            end
         endcase
      end else begin
         unique case (state_ff)
            S_EMIT_RD: begin
               cmd.emit_read = 1'b1;
               state_in      = S_EMIT_SHOW;
            end
            S_EMIT_SHOW: begin
               cmd.show_frame = 1'b1;
               if (rsp_ready) begin
                  if (sts.emit_last) begin
                     cmd.frame_clear = 1'b1;
                     state_in        = S_HUNT;
                  end else begin
                     cmd.emit_next = 1'b1;
                     state_in      = S_EMIT_RD;
                  end
               end
            end
            S_TO_SHOW: begin
               cmd.show_timeout = 1'b1;
               if (rsp_ready) begin
                  state_in = S_HUNT;
               end
            end
            default: begin
               state_in = state_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* tb/tb_msp_frame_receiver.sv */
// Self-checking testbench for the serial command frame receiver.
`timescale 1ns / 100ps

module tb_msp_frame_receiver
   import mfr_pkg::*;
();

   localparam int N_DIRECTED = 31;
   localparam int N_PHASES = 7;
   localparam int RANDOM_ITEMS = 245;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES = 300;
   // The longest quiet spell in a correct run is the receiver hold-off above.
   localparam int STALL_LIMIT = 3000;
   localparam int REPORT_LIMIT = 40;

   typedef enum logic [2:0] {P_HUNT, P_SIZE, P_ID, P_DATA, P_CSUM} rx_phase_type;
   typedef enum logic [1:0] {ROW_BYTE, ROW_TICK, ROW_SETUP} row_kind_type;

   typedef struct packed {
      logic       status;
      logic [7:0] message_id;
      logic [7:0] payload_size;
      logic [5:0] byte_index;
      logic [7:0] data_byte;
      logic       last;
   } rx_word_type;

   // For ROW_BYTE val_a holds the byte; for ROW_SETUP it holds timeout_ticks and
   // val_b max_payload.
   typedef struct packed {
      row_kind_type kind;
      logic [15:0]  val_a;
      logic [6:0]   val_b;
      logic         typed;
      rx_word_type  word;
   } stim_row_type;

   localparam rx_word_type NO_WORD = '0;
   localparam rx_word_type TIMEOUT_WORD = '{ST_TIMEOUT, 8'd0, 8'd0, 6'd0, 8'd0, 1'b1};

   localparam stim_row_type DIRECTED_ROWS [N_DIRECTED] = '{
      '{ROW_TICK, 16'h0000, 7'd0, 1'b0, NO_WORD},
      '{ROW_BYTE, {8'h00, HDR_DOLLAR}, 7'd0, 1'b0, NO_WORD},
      '{ROW_BYTE, {8'h00, HDR_EM}, 7'd0, 1'b0, NO_WORD},
      '{ROW_BYTE, {8'h00, HDR_LESS}, 7'd0, 1'b0, NO_WORD},
      '{ROW_BYTE, 16'h0000, 7'd0, 1'b0, NO_WORD},
      '{ROW_BYTE, 16'h00FF, 7'd0, 1'b0, NO_WORD},
      '{ROW_BYTE, 16'h00FF, 7'd0, 1'b0, NO_WORD},
      '{ROW_SETUP, 16'd1000, 7'd1, 1'b0, NO_WORD},
      '{ROW_BYTE, {8'h00, HDR_DOLLAR}, 7'd0, 1'b0, NO_WORD},
      '{ROW_BYTE, {8'h00, HDR_EM}, 7'd0, 1'b0, NO_WORD},
      '{ROW_BYTE, {8'h00, HDR_LESS}, 7'd0, 1'b0, NO_WORD},
      '{ROW_BYTE, 16'h0002, 7'd0, 1'b0, NO_WORD},
      '{ROW_BYTE, 16'h00A5, 7'd0, 1'b0, NO_WORD},
      '{ROW_BYTE, 16'h00FF, 7'd0, 1'b0, NO_WORD},
      '{ROW_BYTE, 16'h0000, 7'd0, 1'b0, NO_WORD},
      '{ROW_BYTE, 16'h0058, 7'd0, 1'b1, '{ST_PAYLOAD, 8'hA5, 8'h02, 6'd0, 8'hFF, 1'b1}},
      '{ROW_SETUP, 16'd0, 7'd64, 1'b0, NO_WORD},
      '{ROW_BYTE, {8'h00, HDR_DOLLAR}, 7'd0, 1'b0, NO_WORD},
      '{ROW_TICK, 16'h0000, 7'd0, 1'b1, TIMEOUT_WORD},
      '{ROW_SETUP, 16'd1, 7'd127, 1'b0, NO_WORD},
      '{ROW_BYTE, {8'h00, HDR_DOLLAR}, 7'd0, 1'b0, NO_WORD},
      '{ROW_BYTE, {8'h00, HDR_EM}, 7'd0, 1'b0, NO_WORD},
      '{ROW_TICK, 16'h0000, 7'd0, 1'b1, TIMEOUT_WORD},
      '{ROW_SETUP, 16'd1000, 7'd0, 1'b0, NO_WORD},
      '{ROW_BYTE, {8'h00, HDR_DOLLAR}, 7'd0, 1'b0, NO_WORD},
      '{ROW_BYTE, {8'h00, HDR_EM}, 7'd0, 1'b0, NO_WORD},
      '{ROW_BYTE, {8'h00, HDR_LESS}, 7'd0, 1'b0, NO_WORD},
      '{ROW_BYTE, 16'h0001, 7'd0, 1'b0, NO_WORD},
      '{ROW_BYTE, 16'h0080, 7'd0, 1'b0, NO_WORD},
      '{ROW_BYTE, 16'h007F, 7'd0, 1'b0, NO_WORD},
      '{ROW_BYTE, 16'h00FE, 7'd0, 1'b0, NO_WORD}
   };

   localparam logic [15:0] PHASE_TIMEOUT [N_PHASES] = '{16'd1000, 16'd3, 16'd65535,
                                                        16'd20, 16'd1, 16'd8, 16'd200};
   localparam logic [6:0] PHASE_MAX [N_PHASES] = '{7'd64, 7'd5, 7'd64, 7'd0, 7'd100,
                                                  7'd3, 7'd17};

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_opcode;
   logic [7:0]            req_rx_byte;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_status;
   logic [7:0]            rsp_message_id;
   logic [7:0]            rsp_payload_size;
   logic [5:0]            rsp_byte_index;
   logic [7:0]            rsp_data_byte;
   logic                  rsp_last;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   // Mirror of the receiver state, kept in step with every accepted word.
   rx_phase_type rx_phase;
   int unsigned  hdr_count;
   logic [7:0]   hdr_bytes [3];
   logic [7:0]   frm_size;
   logic [7:0]   frm_id;
   logic [7:0]   pay_count;
   logic [7:0]   csum_acc;
   int unsigned  tick_count;
   logic [7:0]   pay_store [BUFFER_DEPTH];
   logic [15:0]  cfg_timeout;
   logic [6:0]   cfg_max;

   rx_word_type  awaited_words [$];
   rx_word_type  produced_words [$];

   int          error_count = 0;
   int unsigned fed_items = 0;
   bit          sender_idles = 1'b1;
   bit          rsp_idles = 1'b1;
   int          hold_wanted = 0;
   int          hold_served = 0;
   int          hold_left = 0;
   int          stall_cycles = 0;

   msp_frame_receiver dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_message_id   (rsp_message_id),
      .rsp_payload_size (rsp_payload_size),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic int unsigned effective_max();
      return (cfg_max > BUFFER_DEPTH) ? BUFFER_DEPTH : cfg_max;
   endfunction

   function automatic bit frame_open();
      return (rx_phase != P_HUNT) || (hdr_count != 0);
   endfunction

   function automatic void restart_hunt();
      rx_phase = P_HUNT;
      hdr_count = 0;
      hdr_bytes = '{default: 8'h00};
      frm_size = 8'h00;
      frm_id = 8'h00;
      pay_count = 8'h00;
      csum_acc = 8'h00;
      tick_count = 0;
   endfunction

   // Advances the mirror by one accepted word and appends the words it causes
   // to produced_words.
   function automatic void decode_rx_word(input logic op, input logic [7:0] b);
      rx_word_type w;
      int unsigned n;
      if (op == OP_TICK) begin
         if (!frame_open())
            return;
         if (tick_count < 65535)
            tick_count++;
         if (tick_count >= cfg_timeout) begin
            produced_words.push_back(TIMEOUT_WORD);
            restart_hunt();
         end
         return;
      end
      case (rx_phase)
         P_HUNT: begin
            if (hdr_count == 0)
               tick_count = 0;
            hdr_bytes[hdr_count] = b;
            hdr_count++;
            if (hdr_count == 3) begin
               if (hdr_bytes[0] == HDR_DOLLAR && hdr_bytes[1] == HDR_EM &&
                   hdr_bytes[2] == HDR_LESS) begin
                  hdr_count = 0;
                  hdr_bytes = '{default: 8'h00};
                  rx_phase = P_SIZE;
               end else begin
                  restart_hunt();
               end
            end
         end
         P_SIZE: begin
            frm_size = b;
            csum_acc = b;
            rx_phase = P_ID;
         end
         P_ID: begin
            frm_id = b;
            csum_acc ^= b;
            pay_count = 8'h00;
            rx_phase = (frm_size == 8'h00) ? P_CSUM : P_DATA;
         end
         P_DATA: begin
            csum_acc ^= b;
            if (pay_count < effective_max())
               pay_store[pay_count] = b;
            pay_count++;
            if (pay_count >= frm_size)
               rx_phase = P_CSUM;
         end
         default: begin
            if (b == csum_acc) begin
               n = effective_max();
               for (int unsigned i = 0; i < n; i++) begin
                  w.status = ST_PAYLOAD;
                  w.message_id = frm_id;
                  w.payload_size = frm_size;
                  w.byte_index = 6'(i);
                  w.data_byte = (i < frm_size) ? pay_store[i] : 8'h00;
                  w.last = (i + 1 == n);
                  produced_words.push_back(w);
               end
            end
            restart_hunt();
         end
      endcase
   endfunction

   // Offers one word and waits for it to be taken. A typed word, where given,
   // replaces whatever the mirror works out for it.
   task automatic send_word(input logic op, input logic [7:0] b, input bit typed = 1'b0,
                            input rx_word_type typed_word = '0);
      while (sender_idles && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      if (op == OP_BYTE || frame_open())
         fed_items++;
      produced_words.delete();
      decode_rx_word(op, b);
      if (typed) begin
         produced_words.delete();
         produced_words.push_back(typed_word);
      end
      while (produced_words.size() != 0)
         awaited_words.push_back(produced_words.pop_front());
   endtask

   task automatic wait_for_all_words();
      req_valid <= 1'b0;
      while (awaited_words.size() != 0)
         @(posedge clock);
   endtask

   // Closes any half-received frame with bytes that cannot yield a result, so
   // that the block is hunting before its registers change.
   task automatic close_open_frame();
      while (frame_open()) begin
         if (rx_phase == P_CSUM)
            send_word(OP_BYTE, csum_acc ^ 8'h01);
         else
            send_word(OP_BYTE, 8'h00);
      end
   endtask

   task automatic change_settings(input logic [15:0] timeout_val, input logic [6:0] max_val);
      close_open_frame();
      wait_for_all_words();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= REG_TIMEOUT_TICKS;
      csr_write_data <= timeout_val;
      @(posedge clock);
      csr_index <= REG_MAX_PAYLOAD;
      csr_write_data <= CSR_DATA_W'(max_val);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_timeout = timeout_val;
      cfg_max = max_val;
   endtask

   // A tick now and then lands inside frames, so short timeouts cut some off.
   task automatic send_frame_byte(input logic [7:0] b);
      if ($urandom_range(99) < 8)
         send_word(OP_TICK, 8'($urandom));
      send_word(OP_BYTE, b);
   endtask

   task automatic send_random_frame();
      logic [7:0]  size;
      logic [7:0]  id;
      logic [7:0]  data;
      logic [7:0]  csum;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 70)
         size = 8'($urandom_range(8));
      else if (pick < 97)
         size = 8'($urandom_range(40, 9));
      else
         size = 8'($urandom_range(120, 65));
      id = 8'($urandom);
      send_frame_byte(HDR_DOLLAR);
      send_frame_byte(HDR_EM);
      send_frame_byte(HDR_LESS);
      send_frame_byte(size);
      send_frame_byte(id);
      csum = size ^ id;
      for (int i = 0; i < size; i++) begin
         data = 8'($urandom);
         csum ^= data;
         send_frame_byte(data);
      end
      if ($urandom_range(99) < 12)
         csum ^= 8'($urandom_range(255, 1));
      send_frame_byte(csum);
   endtask

   // Stray bytes and ticks, broken headers, and frames abandoned after the size.
   task automatic send_noise();
      int unsigned count;
      case ($urandom_range(2))
         0: begin
            count = $urandom_range(4, 1);
            repeat (count)
               send_word(1'($urandom), 8'($urandom));
         end
         1: begin
            send_word(OP_BYTE, HDR_DOLLAR);
            send_word(OP_BYTE, ($urandom_range(1)) ? HDR_EM : 8'($urandom));
            send_word(OP_BYTE, 8'($urandom));
         end
         default: begin
            send_word(OP_BYTE, HDR_DOLLAR);
            send_word(OP_BYTE, HDR_EM);
            send_word(OP_BYTE, HDR_LESS);
            send_word(OP_BYTE, 8'($urandom_range(6)));
         end
      endcase
   endtask

   task automatic run_directed();
      stim_row_type row;
      for (int i = 0; i < N_DIRECTED; i++) begin
         row = DIRECTED_ROWS[i];
         case (row.kind)
            ROW_SETUP: change_settings(row.val_a, row.val_b);
            ROW_TICK:  send_word(OP_TICK, 8'h00, row.typed, row.word);
            default:   send_word(OP_BYTE, row.val_a[7:0], row.typed, row.word);
         endcase
      end
   endtask

   task automatic run_random();
      int unsigned goal;
      bit          paused;
      for (int p = 0; p < N_PHASES; p++) begin
         change_settings(PHASE_TIMEOUT[p], PHASE_MAX[p]);
         // The second setting runs with no idling on either side.
         sender_idles = (p != 1);
         rsp_idles = (p != 1);
         if (p == 2)
            hold_wanted++;
         goal = fed_items + RANDOM_ITEMS / N_PHASES;
         paused = 1'b0;
         while (fed_items < goal) begin
            if (p == 4 && !paused && fed_items + 25 > goal) begin
               wait_for_all_words();
               paused = 1'b1;
            end
            if ($urandom_range(99) < 75)
               send_random_frame();
            else
               send_noise();
         end
      end
   endtask

   function automatic void compare_field(input string field_name, input logic [7:0] want,
                                         input logic [7:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= REPORT_LIMIT)
            $display("%0t ns: %s expected %0h, got %0h", $time, field_name, want, got);
      end
   endfunction

   task automatic check_rx_word();
      rx_word_type want;
      if (awaited_words.size() == 0) begin
         error_count++;
         if (error_count <= REPORT_LIMIT)
            $display("%0t ns: unexpected word, status %0h id %0h size %0h index %0h data %0h",
                     $time, rsp_status, rsp_message_id, rsp_payload_size, rsp_byte_index,
                     rsp_data_byte);
         return;
      end
      want = awaited_words.pop_front();
      compare_field("status", 8'(want.status), 8'(rsp_status));
      compare_field("message_id", want.message_id, rsp_message_id);
      compare_field("payload_size", want.payload_size, rsp_payload_size);
      compare_field("byte_index", 8'(want.byte_index), 8'(rsp_byte_index));
      compare_field("data_byte", want.data_byte, rsp_data_byte);
      compare_field("last", 8'(want.last), 8'(rsp_last));
   endtask

   // Result side: checks each word taken and decides ready for the next edge.
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            check_rx_word();
         if (hold_served != hold_wanted) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= !(rsp_idles && $urandom_range(99) < 30);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t ns: no word moved for %0d cycles", $time, STALL_LIMIT);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_opcode <= OP_BYTE;
      req_rx_byte <= 8'h00;
      csr_write_enable <= 1'b0;
      csr_index <= REG_TIMEOUT_TICKS;
      csr_write_data <= '0;
      cfg_timeout = TIMEOUT_RESET;
      cfg_max = MAX_PAYLOAD_RESET;
      restart_hunt();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      wait_for_all_words();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

/* filelist.f */
sv/mfr_pkg.sv
sv/mfr_datapath.sv
sv/mfr_controller.sv
sv/msp_frame_receiver.sv
tb/tb_msp_frame_receiver.sv
